[rtl/cpsc_pkg.sv]
// Shared types, constants and helper functions of the clamped PID speed controller.
`timescale 1ns / 1ps

package cpsc_pkg;

   // Field widths.
   localparam int unsigned GAIN_W  = 15;
   localparam int unsigned SPEED_W = 16;
   localparam int unsigned ERR_W   = 11;
   localparam int unsigned SUM_W   = 15;
   localparam int unsigned DRIVE_W = 15;
   localparam int unsigned CSR_IDX_W = 2;

   // Limits of the clamped error, error difference, integral and output.
   localparam logic signed [ERR_W-1:0]   ERR_HI    = 11'sd1000;
   localparam logic signed [ERR_W-1:0]   ERR_LO    = -11'sd1000;
   localparam logic signed [ERR_W-1:0]   DIFF_HI   = 11'sd500;
   localparam logic signed [ERR_W-1:0]   DIFF_LO   = -11'sd500;
   localparam logic signed [SUM_W-1:0]   SUM_HI    = 15'sd10000;
   localparam logic signed [SUM_W-1:0]   SUM_LO    = -15'sd10000;
   localparam logic signed [SUM_W-1:0]   SUM_RESET = -15'sd1000;
   localparam logic signed [DRIVE_W-1:0] OUT_HI    = 15'sd10000;
   localparam logic signed [DRIVE_W-1:0] OUT_LO    = -15'sd10000;

   // Right shifts applied to the proportional, integral and derivative terms.
   localparam int unsigned P_SHIFT  = 4;
   localparam int unsigned ID_SHIFT = 2;

   // Gain value after reset.
   localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd1;

   // Item modes.
   localparam logic MODE_STEP  = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN  = 2'd0,
      CSR_INTEG_GAIN = 2'd1,
      CSR_DERIV_GAIN = 2'd2
   } csr_index_type;

   // The three gains as seen by the back end.
   typedef struct packed {
      logic [GAIN_W-1:0] prop;
      logic [GAIN_W-1:0] integ;
      logic [GAIN_W-1:0] deriv;
   } gains_type;

   // Terms handed from the front end to the back end for one item.
   typedef struct packed {
      logic signed [ERR_W-1:0] err;
      logic signed [SUM_W-1:0] sum;
      logic signed [ERR_W-1:0] diff;
   } terms_type;

   // Queue occupancy flags.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Widest product: 16-bit zero-extended gain times a 15-bit integral.
   localparam int unsigned PROD_W = 31;

   // Saturates a full-width gain product to the output limits.
   function automatic logic signed [DRIVE_W-1:0] sat_product(
      input logic signed [PROD_W-1:0] value
   );
      logic signed [DRIVE_W-1:0] result;
      if (value > OUT_HI) begin
         result = OUT_HI;
      end else if (value < OUT_LO) begin
         result = OUT_LO;
      end else begin
         result = value[DRIVE_W-1:0];
      end
      return result;
   endfunction

endpackage

[rtl/clamped_pid_speed_controller.sv]
// Top level of the clamped PID speed controller: gain registers, front end, queue, back end.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_mode, req_target, req_actual
//   rsp_      out        rsp_valid/rsp_stall  rsp_drive
//   csr_      in         csr_write_enable     csr_index, csr_data
//
// One item is accepted per cycle while the queue is not full; a compute item's drive goes
// through the queue write at the accepting edge, the product stage and the output register.
// Clear items update the state in the cycle they are accepted and give no result.
// Reset sets all gains to one, the integral to minus one thousand and the last error to zero.
// req_stall rises only when the queue is full; rsp_stall holds the back end while the
// front end keeps filling the queue.
`timescale 1ns / 1ps

module clamped_pid_speed_controller #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic signed [cpsc_pkg::SPEED_W-1:0]   req_target,
   input  logic signed [cpsc_pkg::SPEED_W-1:0]   req_actual,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cpsc_pkg::DRIVE_W-1:0]   rsp_drive,
   input  logic                                  csr_write_enable,
   input  logic [cpsc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cpsc_pkg::GAIN_W-1:0]           csr_data
);
   import cpsc_pkg::*;

   gains_type        gains_ff, gains_in;
   queue_status_type queue_status;
   logic             push;
   logic             pop;
   terms_type        push_data;
   terms_type        pop_data;

   // Gain registers; writes to an unused index are dropped.
   always_comb begin
      gains_in = gains_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PROP_GAIN:  gains_in.prop  = csr_data;
            CSR_INTEG_GAIN: gains_in.integ = csr_data;
            CSR_DERIV_GAIN: gains_in.deriv = csr_data;
            default:        gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.prop  <= GAIN_RESET;
         gains_ff.integ <= GAIN_RESET;
         gains_ff.deriv <= GAIN_RESET;
      end else begin
         gains_ff <= gains_in;
      end
   end

   // Front end: item intake and controller state.
   cpsc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_target   (req_target),
      .req_actual   (req_actual),
      .queue_status (queue_status),
      .push         (push),
      .push_data    (push_data)
   );

   // Decoupling queue.
   cpsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   // Back end: gain arithmetic and result register.
   cpsc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .gains        (gains_ff),
      .queue_status (queue_status),
      .pop          (pop),
      .pop_data     (pop_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_drive    (rsp_drive)
   );

`ifndef SYNTHESIS
   // A delivered drive always lies within the output limits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive <= OUT_HI) && (rsp_drive >= OUT_LO))
      else $error("drive outside output limits");

   // A full queue must hold off the input channel.
   assert property (@(posedge clock) disable iff (reset)
      queue_status.full |-> req_stall)
      else $error("input not stalled while queue full");

   // An accepted compute item leaves the queue non-empty.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_mode == MODE_STEP)) |=> !queue_status.empty)
      else $error("compute item lost before queue");
`endif

endmodule

[rtl/cpsc_queue.sv]
// Short item queue between the front end and the back end.
`timescale 1ns / 1ps

module cpsc_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  cpsc_pkg::terms_type          push_data,
   input  logic                         pop,
   output cpsc_pkg::terms_type          pop_data,
   output cpsc_pkg::queue_status_type   status
);
   import cpsc_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   terms_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Pointer and occupancy update.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[head_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

endmodule

[rtl/cpsc_front.sv]
// Front end: accepts items, keeps the integral and last error, forms the clamped terms.
`timescale 1ns / 1ps

module cpsc_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic signed [cpsc_pkg::SPEED_W-1:0]   req_target,
   input  logic signed [cpsc_pkg::SPEED_W-1:0]   req_actual,
   input  cpsc_pkg::queue_status_type            queue_status,
   output logic                                  push,
   output cpsc_pkg::terms_type                   push_data
);
   import cpsc_pkg::*;

   logic signed [SUM_W-1:0] error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0] previous_error_ff, previous_error_in;

   logic                      accept;
   logic signed [SPEED_W:0]   err_raw;
   logic signed [ERR_W-1:0]   err;
   logic signed [SUM_W:0]     sum_raw;
   logic signed [SUM_W-1:0]   sum;
   logic signed [ERR_W:0]     diff_raw;
   logic signed [ERR_W-1:0]   diff;

   // The input waits whenever the queue is full, for clear items as well.
   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (req_mode == MODE_STEP);

   // Error, integral and error difference, each clamped.
   always_comb begin
      err_raw = {req_target[SPEED_W-1], req_target} - {req_actual[SPEED_W-1], req_actual};
      if (err_raw > ERR_HI) begin
         err = ERR_HI;
      end else if (err_raw < ERR_LO) begin
         err = ERR_LO;
      end else begin
         err = err_raw[ERR_W-1:0];
      end

      sum_raw = {error_sum_ff[SUM_W-1], error_sum_ff} + (SUM_W+1)'(err);
      if (sum_raw > SUM_HI) begin
         sum = SUM_HI;
      end else if (sum_raw < SUM_LO) begin
         sum = SUM_LO;
      end else begin
         sum = sum_raw[SUM_W-1:0];
      end

      diff_raw = {err[ERR_W-1], err} - {previous_error_ff[ERR_W-1], previous_error_ff};
      if (diff_raw > DIFF_HI) begin
         diff = DIFF_HI;
      end else if (diff_raw < DIFF_LO) begin
         diff = DIFF_LO;
      end else begin
         diff = diff_raw[ERR_W-1:0];
      end
   end

   assign push_data.err  = err;
   assign push_data.sum  = sum;
   assign push_data.diff = diff;

   // Controller state follows every accepted item.
   always_comb begin
      error_sum_in      = error_sum_ff;
      previous_error_in = previous_error_ff;
      if (accept) begin
         if (req_mode == MODE_CLEAR) begin
            error_sum_in      = '0;
            previous_error_in = '0;
         end else begin
            error_sum_in      = sum;
            previous_error_in = err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff      <= SUM_RESET;
         previous_error_ff <= '0;
      end else begin
         error_sum_ff      <= error_sum_in;
         previous_error_ff <= previous_error_in;
      end
   end

endmodule

[rtl/cpsc_back.sv]
// Back end: gain products, saturation, shifts and the output register.
`timescale 1ns / 1ps

module cpsc_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cpsc_pkg::gains_type                   gains,
   input  cpsc_pkg::queue_status_type            queue_status,
   output logic                                  pop,
   input  cpsc_pkg::terms_type                   pop_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cpsc_pkg::DRIVE_W-1:0]   rsp_drive
);
   import cpsc_pkg::*;

   localparam int unsigned EP_W = GAIN_W + ERR_W + 1;

   logic                      prod_valid_ff, prod_valid_in;
   logic signed [EP_W-1:0]    p_prod_ff, p_prod_in;
   logic signed [PROD_W-1:0]  i_prod_ff, i_prod_in;
   logic signed [EP_W-1:0]    d_prod_ff, d_prod_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_W-1:0] rsp_drive_ff, rsp_drive_in;

   logic                      out_ready;
   logic                      prod_ready;
   logic signed [DRIVE_W-1:0] p_term;
   logic signed [DRIVE_W-1:0] i_term;
   logic signed [DRIVE_W-1:0] d_term;
   logic signed [DRIVE_W:0]   total;

   // Stage handshakes: each stage moves when the one after it has room.
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign prod_ready = !prod_valid_ff || out_ready;
   assign pop        = prod_ready && !queue_status.empty;

   // Product stage: gains are zero-extended so the products are exact.
   always_comb begin
      prod_valid_in = prod_ready ? !queue_status.empty : prod_valid_ff;
      p_prod_in     = $signed({1'b0, gains.prop})  * pop_data.err;
      i_prod_in     = $signed({1'b0, gains.integ}) * pop_data.sum;
      d_prod_in     = $signed({1'b0, gains.deriv}) * pop_data.diff;
   end

   // Output stage: saturate each product, shift, add and saturate again.
   always_comb begin
      p_term = sat_product(PROD_W'(p_prod_ff)) >>> P_SHIFT;
      i_term = sat_product(i_prod_ff) >>> ID_SHIFT;
      d_term = sat_product(PROD_W'(d_prod_ff)) >>> ID_SHIFT;
      total  = (DRIVE_W+1)'(p_term) + (DRIVE_W+1)'(i_term) + (DRIVE_W+1)'(d_term);
      if (total > OUT_HI) begin
         rsp_drive_in = OUT_HI;
      end else if (total < OUT_LO) begin
         rsp_drive_in = OUT_LO;
      end else begin
         rsp_drive_in = total[DRIVE_W-1:0];
      end
      rsp_valid_in = out_ready ? prod_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers load only when their stage advances.
   always_ff @(posedge clock) begin
      if (prod_ready) begin
         p_prod_ff <= p_prod_in;
         i_prod_ff <= i_prod_in;
         d_prod_ff <= d_prod_in;
      end
      if (out_ready) begin
         rsp_drive_ff <= rsp_drive_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the clamped PID speed controller: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
   import cpsc_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 6;
   localparam int IDLE_PERCENT    = 9;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int QUIET_PHASE     = 2;
   localparam int HOLD_START_ITEM = 10;
   localparam int HOLD_CYCLES     = 80;
   localparam int SETTLE_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int MAX_PRINTED     = 40;

   // Index past the three gain registers; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      ROW_STEP,
      ROW_CLEAR,
      ROW_GAIN
   } row_kind_type;

   // One row of the directed table: an item, or a gain write done while the block is idle.
   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_IDX_W-1:0]      index;
      logic [GAIN_W-1:0]         gain;
      logic signed [SPEED_W-1:0] target;
      logic signed [SPEED_W-1:0] actual;
      logic                      has_drive;
      logic signed [DRIVE_W-1:0] drive;
   } stim_row_type;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_stall;
   logic                      req_mode         = MODE_STEP;
   logic signed [SPEED_W-1:0] req_target       = '0;
   logic signed [SPEED_W-1:0] req_actual       = '0;
   logic                      rsp_valid;
   logic                      rsp_stall        = 1'b0;
   logic signed [DRIVE_W-1:0] rsp_drive;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index        = '0;
   logic [GAIN_W-1:0]         csr_data         = '0;

   // Predicted controller state and gains.
   logic [GAIN_W-1:0] prop_gain_now  = GAIN_RESET;
   logic [GAIN_W-1:0] integ_gain_now = GAIN_RESET;
   logic [GAIN_W-1:0] deriv_gain_now = GAIN_RESET;
   longint            integral_now   = longint'(SUM_RESET);
   longint            last_error_now = 0;

   logic signed [DRIVE_W-1:0] drive_expect_q[$];

   int mismatches         = 0;
   int items_sent         = 0;
   int clears_sent        = 0;
   int drives_checked     = 0;
   int gain_settings      = 0;
   int integ_saturations  = 0;
   int input_stall_cycles = 0;
   int stuck_cycles       = 0;
   bit no_idle            = 1'b0;
   bit hold_request       = 1'b0;

   clamped_pid_speed_controller uut (.*);

   always #HALF_PERIOD clock = ~clock;

   task automatic report_mismatch(input string detail);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("%0t: %s", $time, detail);
      end
   endtask

   function automatic longint clip(input longint value, input longint limit);
      if (value > limit) return limit;
      if (value < -limit) return -limit;
      return value;
   endfunction

   // One PID step on the predicted state; returns the drive the block must produce.
   function automatic logic signed [DRIVE_W-1:0] pid_step_drive(
      input logic signed [SPEED_W-1:0] target,
      input logic signed [SPEED_W-1:0] actual
   );
      longint err;
      longint sum;
      longint diff;
      longint total;
      err  = clip(longint'(target) - longint'(actual), longint'(ERR_HI));
      sum  = clip(integral_now + err, longint'(SUM_HI));
      diff = clip(err - last_error_now, longint'(DIFF_HI));
      integral_now   = sum;
      last_error_now = err;
      if (sum == longint'(SUM_HI) || sum == longint'(SUM_LO)) begin
         integ_saturations++;
      end
      total = (clip(longint'(prop_gain_now) * err, longint'(OUT_HI)) >>> P_SHIFT)
            + (clip(longint'(integ_gain_now) * sum, longint'(OUT_HI)) >>> ID_SHIFT)
            + (clip(longint'(deriv_gain_now) * diff, longint'(OUT_HI)) >>> ID_SHIFT);
      total = clip(total, longint'(OUT_HI));
      return total[DRIVE_W-1:0];
   endfunction

   function automatic stim_row_type item_row(
      input row_kind_type kind,
      input int           target,
      input int           actual
   );
      stim_row_type row;
      row        = '0;
      row.kind   = kind;
      row.target = target[SPEED_W-1:0];
      row.actual = actual[SPEED_W-1:0];
      return row;
   endfunction

   function automatic stim_row_type known_row(input int target, input int actual, input int drive);
      stim_row_type row;
      row           = item_row(ROW_STEP, target, actual);
      row.has_drive = 1'b1;
      row.drive     = drive[DRIVE_W-1:0];
      return row;
   endfunction

   function automatic stim_row_type gain_row(input logic [CSR_IDX_W-1:0] index, input int gain);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_GAIN;
      row.index = index;
      row.gain  = gain[GAIN_W-1:0];
      return row;
   endfunction

   // Gains lean toward the extremes and small values, where rounding and clamping show.
   function automatic logic [GAIN_W-1:0] pick_gain();
      int choice;
      int gain;
      choice = $urandom_range(0, 9);
      case (choice)
         0: gain = 0;
         1: gain = 1;
         2: gain = 32767;
         3, 4, 5: gain = $urandom_range(0, 64);
         6, 7: gain = $urandom_range(0, 2047);
         default: gain = $urandom_range(0, 32767);
      endcase
      return gain[GAIN_W-1:0];
   endfunction

   // Offer one item, hold it until it is taken, then record what it should produce.
   task automatic send_item(
      input logic                      mode,
      input logic signed [SPEED_W-1:0] target,
      input logic signed [SPEED_W-1:0] actual,
      input logic                      has_drive,
      input logic signed [DRIVE_W-1:0] typed_drive
   );
      logic signed [DRIVE_W-1:0] predicted;
      if (!no_idle) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_target <= target;
      req_actual <= actual;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (mode == MODE_CLEAR) begin
         integral_now   = 0;
         last_error_now = 0;
         clears_sent++;
      end else begin
         predicted = pid_step_drive(target, actual);
         drive_expect_q.push_back(has_drive ? typed_drive : predicted);
      end
   endtask

   // Stop offering and let every expected drive go through.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (drive_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gain(input logic [CSR_IDX_W-1:0] index, input logic [GAIN_W-1:0] gain);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= gain;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         CSR_PROP_GAIN:  prop_gain_now  = gain;
         CSR_INTEG_GAIN: integ_gain_now = gain;
         CSR_DERIV_GAIN: deriv_gain_now = gain;
         default: ;
      endcase
   endtask

   // A random phase: fresh gains, then items with small, wrapped, drifting or wild errors.
   task automatic run_random_phase(input int phase);
      int                        drift;
      int                        pick;
      int                        raw;
      int                        count;
      logic signed [SPEED_W-1:0] target;
      logic signed [SPEED_W-1:0] actual;
      drain_results();
      write_gain(CSR_PROP_GAIN, pick_gain());
      write_gain(CSR_INTEG_GAIN, pick_gain());
      write_gain(CSR_DERIV_GAIN, pick_gain());
      if ($urandom_range(0, 3) == 0) begin
         write_gain(CSR_UNUSED, pick_gain());
      end
      gain_settings++;
      no_idle = (phase == QUIET_PHASE);
      drift   = $urandom_range(0, 2) - 1;
      for (count = 0; count < ITEMS_PER_PHASE; count++) begin
         if (no_idle && count == HOLD_START_ITEM) begin
            hold_request = 1'b1;
         end
         raw    = $urandom;
         actual = raw[SPEED_W-1:0];
         pick   = $urandom_range(0, 99);
         raw    = $urandom;
         if (pick < 40) begin
            raw = int'(actual) + $urandom_range(0, 2400) - 1200;
         end else if (pick >= 60) begin
            raw = int'(actual) + drift * $urandom_range(0, 1500) + $urandom_range(0, 200) - 100;
         end
         target = raw[SPEED_W-1:0];
         send_item((pick < 4) ? MODE_CLEAR : MODE_STEP, target, actual, 1'b0, '0);
      end
      no_idle = 1'b0;
   endtask

   // Receiver: random stalls, none in the quiet phase, and one long hold-off on request.
   initial begin : receiver
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // Each accepted drive is compared with the oldest expectation.
   always @(posedge clock) begin : check_drive
      logic signed [DRIVE_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drive_expect_q.size() == 0) begin
            report_mismatch($sformatf("drive %0d arrived with no item waiting", rsp_drive));
         end else begin
            want = drive_expect_q.pop_front();
            drives_checked++;
            if (rsp_drive !== want) begin
               report_mismatch($sformatf("drive %0d, expected %0d", rsp_drive, want));
            end
         end
      end
   end

   // Watchdog: ends the run when nothing has moved for too long.
   always @(posedge clock) begin : watchdog
      if (!reset && req_valid && req_stall) begin
         input_stall_cycles++;
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("No item moved for %0d cycles.", WATCHDOG_LIMIT);
         $display("clamped_pid_speed_controller: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type directed_rows[$];
      int           phase;

      // Reset gains: integral starts at minus one thousand, full-scale errors clamp.
      directed_rows.push_back(known_row(0, 0, -250));
      directed_rows.push_back(item_row(ROW_CLEAR, 1234, -77));
      directed_rows.push_back(known_row(32767, -32768, 437));
      directed_rows.push_back(known_row(-32768, 32767, -188));
      directed_rows.push_back(known_row(-32768, -32768, 125));
      directed_rows.push_back(known_row(32767, 32767, 0));
      // Largest gains: nonzero products saturate.
      directed_rows.push_back(gain_row(CSR_PROP_GAIN, 32767));
      directed_rows.push_back(gain_row(CSR_INTEG_GAIN, 32767));
      directed_rows.push_back(gain_row(CSR_DERIV_GAIN, 32767));
      directed_rows.push_back(item_row(ROW_CLEAR, 0, 0));
      directed_rows.push_back(known_row(1, 0, 5625));
      directed_rows.push_back(known_row(-32768, 32767, -5625));
      directed_rows.push_back(item_row(ROW_STEP, -1, 0));
      directed_rows.push_back(item_row(ROW_STEP, 700, -300));
      directed_rows.push_back(item_row(ROW_STEP, 500, -501));
      // Zero gains, then a write to the unused index that must not take effect.
      directed_rows.push_back(gain_row(CSR_PROP_GAIN, 0));
      directed_rows.push_back(gain_row(CSR_INTEG_GAIN, 0));
      directed_rows.push_back(gain_row(CSR_DERIV_GAIN, 0));
      directed_rows.push_back(gain_row(CSR_UNUSED, 32767));
      directed_rows.push_back(known_row(5, -5, 0));
      // Proportional term alone, then odd gains for rounding of negative terms.
      directed_rows.push_back(gain_row(CSR_PROP_GAIN, 16));
      directed_rows.push_back(known_row(100, 0, 100));
      directed_rows.push_back(known_row(-100, 0, -100));
      directed_rows.push_back(gain_row(CSR_DERIV_GAIN, 3));
      directed_rows.push_back(item_row(ROW_STEP, -1, 0));
      directed_rows.push_back(gain_row(CSR_INTEG_GAIN, 5));
      directed_rows.push_back(item_row(ROW_STEP, 1000, 0));
      directed_rows.push_back(item_row(ROW_CLEAR, -32768, 32767));
      directed_rows.push_back(item_row(ROW_STEP, 0, 1));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table.
      foreach (directed_rows[n]) begin
         case (directed_rows[n].kind)
            ROW_GAIN: begin
               drain_results();
               write_gain(directed_rows[n].index, directed_rows[n].gain);
            end
            ROW_CLEAR: begin
               send_item(MODE_CLEAR, directed_rows[n].target, directed_rows[n].actual,
                         1'b0, '0);
            end
            default: begin
               send_item(MODE_STEP, directed_rows[n].target, directed_rows[n].actual,
                         directed_rows[n].has_drive, directed_rows[n].drive);
            end
         endcase
      end

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         run_random_phase(phase);
      end
      drain_results();

      $display("Sent %0d items (%0d clears), checked %0d drives over %0d random gain settings.",
               items_sent, clears_sent, drives_checked, gain_settings);
      $display("Integral sat at its limit on %0d steps; the input was stalled for %0d cycles.",
               integ_saturations, input_stall_cycles);
      if (mismatches == 0) begin
         $display("clamped_pid_speed_controller: match");
      end else begin
         $display("clamped_pid_speed_controller: mismatch");
      end
      $finish;
   end

endmodule

[clamped_pid_speed_controller.f]
rtl/cpsc_pkg.sv
rtl/cpsc_queue.sv
rtl/cpsc_front.sv
rtl/cpsc_back.sv
rtl/clamped_pid_speed_controller.sv
verif/tb_top.sv
